@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Same check on the house clock and reset.
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

@@ hw/rtl/pru_pkg.sv @@
`timescale 1ns / 1ps

package pru_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_SCALE = 64;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RPT_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SCALE_W = 7;
  localparam int WIDTH_W = 11;
  localparam int CFG_W   = 11;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [0:0] {
    CFG_SCALE = 1'b0,
    CFG_WIDTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    REQ_PIXEL = 1'b0,
    REQ_PULL  = 1'b1
  } req_type_e;

  // One queued burst: a pixel to be sent scale times.
  typedef struct packed {
    logic [23:0]      pixel;
    logic [RPT_W-1:0] scale_m1;
    logic             row_end;
    logic [1:0]       pad;
  } cmd_t;

endpackage

@@ hw/rtl/pru_in_if.sv @@
`timescale 1ns / 1ps

interface pru_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output req_type, output blue, output green, output red,
                  input ready);
  modport sink   (input valid, input req_type, input blue, input green, input red,
                  output ready);
endinterface

@@ hw/rtl/pru_out_if.sv @@
`timescale 1ns / 1ps

interface pru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [1:0] pad_bytes;
  logic       row_end;
  logic       last;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output pad_bytes, output row_end, output last, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input pad_bytes, input row_end, input last, output ready);
endinterface

@@ hw/rtl/pru_fifo.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pru_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pru_pkg::cmd_t push_cmd_i,
  output logic          ready_o,
  output logic          valid_o,
  output pru_pkg::cmd_t head_o,
  input  logic          pop_i
);
  import pru_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q, count_d;

  assign ready_o = (count_q != (QPTR_W+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  `ASSERT_STD(a_pop_nonempty, pop_i |-> count_q != '0)
  `ASSERT_STD(a_push_not_full, push_i |-> count_q != (QPTR_W+1)'(QDEPTH))

endmodule

@@ hw/rtl/pru_front.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pru_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  pru_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [pru_pkg::CFG_W-1:0] cfg_wdata_i,
  pru_in_if.sink                    in_if,
  output logic                      q_push_o,
  output pru_pkg::cmd_t             q_cmd_o,
  input  logic                      q_ready_i
);
  import pru_pkg::*;

  logic [SCALE_W-1:0] scale_q;
  logic [WIDTH_W-1:0] width_q;

  logic [23:0]      line_store_q [MAX_WIDTH];
  logic [23:0]      rdata_q;
  logic [COL_W-1:0] wcol_q, rcol_q;
  logic [RPT_W-1:0] rl_q;

  logic             st_valid_q;
  logic             st_mem_q;
  logic [23:0]      st_pix_q;
  logic [RPT_W-1:0] st_scale_m1_q;
  logic             st_end_q;
  logic [1:0]       st_pad_q;

  logic [SCALE_W-1:0] eff_s;
  logic [COL_W:0]     eff_w;
  logic [COL_W:0]     last_col_w;
  logic [COL_W-1:0]   last_col;
  logic [3:0]         pad_prod;
  logic [RPT_W-1:0]   s_m1;
  logic               accept, is_pix, emit, at_end;
  logic [COL_W-1:0]   col;
  logic [23:0]        in_pix;

  always_comb begin
    eff_s = scale_q;
    if (scale_q == '0) begin
      eff_s = SCALE_W'(1);
    end else if (scale_q > SCALE_W'(MAX_SCALE)) begin
      eff_s = SCALE_W'(MAX_SCALE);
    end
    if (width_q == '0) begin
      eff_w = (COL_W+1)'(1);
    end else if ({21'd0, width_q} > MAX_WIDTH) begin
      eff_w = (COL_W+1)'(MAX_WIDTH);
    end else begin
      eff_w = (COL_W+1)'(width_q);
    end
  end

  assign last_col_w = eff_w - 1'b1;
  assign last_col   = last_col_w[COL_W-1:0];
  assign s_m1       = RPT_W'(eff_s - 1'b1);
  // row bytes w*s*3 padded to a word: pad is (w*s) mod 4
  assign pad_prod   = 4'(eff_w[1:0]) * 4'(eff_s[1:0]);

  assign in_pix   = {in_if.red, in_if.green, in_if.blue};
  assign in_if.ready = !st_valid_q || q_ready_i;
  assign accept   = in_if.valid && in_if.ready;
  assign is_pix   = (in_if.req_type == REQ_PIXEL);
  assign emit     = is_pix ? (rl_q == '0) : (rl_q != '0);
  assign col      = is_pix ? wcol_q : rcol_q;
  assign at_end   = (col >= last_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(1);
      width_q <= WIDTH_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE: scale_q <= cfg_wdata_i[SCALE_W-1:0];
        CFG_WIDTH: width_q <= cfg_wdata_i[WIDTH_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q     <= '0;
      rcol_q     <= '0;
      rl_q       <= '0;
      st_valid_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        st_valid_q <= accept && emit;
      end
      if (accept && emit) begin
        if (is_pix) begin
          if (at_end) begin
            wcol_q <= '0;
            rcol_q <= '0;
            rl_q   <= s_m1;
          end else begin
            wcol_q <= wcol_q + 1'b1;
          end
        end else begin
          if (at_end) begin
            rcol_q <= '0;
            rl_q   <= rl_q - 1'b1;
          end else begin
            rcol_q <= rcol_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      if (is_pix) begin
        line_store_q[wcol_q] <= in_pix;
      end else begin
        rdata_q <= line_store_q[rcol_q];
      end
      st_mem_q      <= !is_pix;
      st_pix_q      <= in_pix;
      st_scale_m1_q <= s_m1;
      st_end_q      <= at_end;
      st_pad_q      <= at_end ? pad_prod[1:0] : 2'd0;
    end
  end

  assign q_push_o         = st_valid_q && q_ready_i;
  assign q_cmd_o.pixel    = st_mem_q ? rdata_q : st_pix_q;
  assign q_cmd_o.scale_m1 = st_scale_m1_q;
  assign q_cmd_o.row_end  = st_end_q;
  assign q_cmd_o.pad      = st_pad_q;

  `ASSERT_STD(a_replay_col_home, rl_q != '0 |-> wcol_q == '0)
  `ASSERT_STD(a_stage_holds, st_valid_q && !q_ready_i |=> st_valid_q && $stable(st_pix_q))

endmodule

@@ hw/rtl/pru_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pru_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  pru_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  pru_out_if.source     out_if
);
  import pru_pkg::*;

  logic [RPT_W-1:0] k_q;
  logic             out_valid_q;
  logic [23:0]      out_pix_q;
  logic [1:0]       out_pad_q;
  logic             out_end_q;
  logic             out_last_q;

  logic load, fin;

  assign load    = q_valid_i && (!out_valid_q || out_if.ready);
  assign fin     = (k_q == q_cmd_i.scale_m1);
  assign q_pop_o = load && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        k_q         <= fin ? '0 : k_q + 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pix_q  <= q_cmd_i.pixel;
      out_pad_q  <= fin ? q_cmd_i.pad : 2'd0;
      out_end_q  <= fin && q_cmd_i.row_end;
      out_last_q <= fin;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_blue  = out_pix_q[7:0];
  assign out_if.out_green = out_pix_q[15:8];
  assign out_if.out_red   = out_pix_q[23:16];
  assign out_if.pad_bytes = out_pad_q;
  assign out_if.row_end   = out_end_q;
  assign out_if.last      = out_last_q;

  `ASSERT_STD(a_pop_gives_last, q_pop_o |=> out_valid_q && out_last_q)
  `ASSERT_STD(a_row_end_last, out_valid_q && out_end_q |-> out_last_q)

endmodule

@@ hw/rtl/pixel_replication_upscaler.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake           Payload
// in_if     in   valid/ready         req_type, blue, green, red
// out_if    out  valid/ready         out_blue, out_green, out_red, pad_bytes, row_end, last
// cfg       in   cfg_we_i            cfg_idx_i, cfg_wdata_i
//
// A request is taken every cycle while the command queue has room; each producing
// request then yields scale output pixels through the single output register of the
// back end, one per cycle while out_if is ready.
// Stored pixels are read from the line store into rdata_q when the pull is taken.
// Reset clears columns, replay count, queue and valids; the line store is not cleared.
// Either side may stall freely; the four-entry queue decouples front and back.

module pixel_replication_upscaler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  pru_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [pru_pkg::CFG_W-1:0] cfg_wdata_i,
  pru_in_if.sink                    in_if,
  pru_out_if.source                 out_if
);
  import pru_pkg::*;

  logic push, q_ready, q_valid, pop;
  cmd_t push_cmd, head_cmd;

  pru_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .q_push_o    (push),
    .q_cmd_o     (push_cmd),
    .q_ready_i   (q_ready)
  );

  pru_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (head_cmd),
    .pop_i      (pop)
  );

  pru_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (pop),
    .out_if    (out_if)
  );

endmodule

@@ sim/pixel_replication_upscaler_tb.sv @@
`timescale 1ns / 1ps

module pixel_replication_upscaler_tb;
  import pru_pkg::*;

  localparam int LAT        = 16;
  localparam int LONG_HOLD  = 300;
  localparam int ITEM_GOAL  = 420;
  localparam int QUIET_FROM = 360;

  typedef struct {
    req_type_e  kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] pad;
    logic       row_end;
    logic       last_px;
  } up_px_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_e    cfg_idx = CFG_SCALE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pru_in_if  in_ch ();
  pru_out_if out_ch ();

  pixel_replication_upscaler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // predicted block state
  logic [23:0]  row_buf [0:MAX_WIDTH-1];
  logic [6:0]   scale_reg = 7'd1;
  logic [10:0]  width_reg = 11'd1;
  int unsigned  wr_col = 0;
  int unsigned  rp_col = 0;
  int unsigned  rp_left = 0;
  int unsigned  written_cnt = 0;
  int unsigned  produced_cnt = 0;

  pix_req_t req_q [$];
  up_px_t   upscaled_q [$];
  pix_req_t cur_req;
  up_px_t   want_px;

  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned sink_hold_cnt = 0;
  bit          sink_hold_req = 1'b0;
  bit          idle_on = 1'b1;
  bit          quiet = 1'b0;
  bit          noisy = 1'b0;
  int unsigned fail_cnt = 0;

  function automatic int unsigned eff_scale();
    if (scale_reg == 0) return 1;
    if (scale_reg > MAX_SCALE) return MAX_SCALE;
    return scale_reg;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  task automatic push_copies(input logic [23:0] pix, input int unsigned s, input bit at_end);
    up_px_t      px;
    int unsigned pad;
    pad = at_end ? (4 - (eff_width() * s * 3) % 4) % 4 : 0;
    for (int unsigned k = 0; k < s; k++) begin
      px.blue    = pix[7:0];
      px.green   = pix[15:8];
      px.red     = pix[23:16];
      px.last_px = (k + 1 == s);
      px.pad     = px.last_px ? pad[1:0] : 2'd0;
      px.row_end = px.last_px && at_end;
      upscaled_q.push_back(px);
    end
  endtask

  task automatic predict_request(input pix_req_t q);
    int unsigned s;
    int unsigned lc;
    bit          at_end;
    logic [23:0] pix;
    s  = eff_scale();
    lc = eff_width() - 1;
    if (q.kind == REQ_PIXEL) begin
      if (rp_left != 0) return;
      pix = {q.red, q.green, q.blue};
      row_buf[wr_col] = pix;
      if (wr_col + 1 > written_cnt) written_cnt = wr_col + 1;
      at_end = (wr_col >= lc);
      push_copies(pix, s, at_end);
      if (at_end) begin
        wr_col  = 0;
        rp_col  = 0;
        rp_left = (s - 1) & 63;
      end else begin
        wr_col++;
      end
    end else begin
      if (rp_left == 0) return;
      pix    = row_buf[rp_col];
      at_end = (rp_col >= lc);
      push_copies(pix, s, at_end);
      if (at_end) begin
        rp_col = 0;
        rp_left--;
      end else begin
        rp_col++;
      end
    end
    produced_cnt++;
    if (produced_cnt >= QUIET_FROM) quiet = 1'b1;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_request(cur_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          cur_req = req_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.req_type <= cur_req.kind;
          in_ch.blue     <= cur_req.blue;
          in_ch.green    <= cur_req.green;
          in_ch.red      <= cur_req.red;
          if (idle_on && !quiet && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 18);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (upscaled_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h/%0h/%0h", $time,
                   out_ch.out_blue, out_ch.out_green, out_ch.out_red);
          fail_cnt++;
        end else begin
          want_px = upscaled_q.pop_front();
          check_field("out_blue", want_px.blue, out_ch.out_blue);
          check_field("out_green", want_px.green, out_ch.out_green);
          check_field("out_red", want_px.red, out_ch.out_red);
          check_field("pad_bytes", want_px.pad, out_ch.pad_bytes);
          check_field("row_end", want_px.row_end, out_ch.row_end);
          check_field("last", want_px.last_px, out_ch.last);
        end
      end
      if (sink_hold_cnt != 0) begin
        sink_hold_cnt--;
        out_ch.ready <= 1'b0;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_hold_cnt = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && !quiet && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 18);
      end
    end
  end

  function automatic pix_req_t rand_req(input req_type_e kind);
    pix_req_t q;
    q.kind  = kind;
    q.blue  = 8'($urandom_range(0, 255));
    q.green = 8'($urandom_range(0, 255));
    q.red   = 8'($urandom_range(0, 255));
    return q;
  endfunction

  task automatic push_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    pix_req_t q;
    q.kind  = REQ_PIXEL;
    q.blue  = b;
    q.green = g;
    q.red   = r;
    req_q.push_back(q);
  endtask

  task automatic push_pulls(input int unsigned n);
    repeat (n) req_q.push_back(rand_req(REQ_PULL));
  endtask

  task automatic add_noise();
    if (noisy && $urandom_range(0, 11) == 0)
      req_q.push_back(rand_req($urandom_range(0, 1) ? REQ_PULL : REQ_PIXEL));
  endtask

  // one input row followed by its replay pulls, now and then cut short
  task automatic fill_row(input int unsigned s, input int unsigned w);
    int unsigned npull;
    npull = (s - 1) * w;
    if ($urandom_range(0, 9) == 0) npull = $urandom_range(0, npull);
    for (int unsigned c = 0; c < w; c++) begin
      add_noise();
      req_q.push_back(rand_req(REQ_PIXEL));
    end
    for (int unsigned k = 0; k < npull; k++) begin
      add_noise();
      req_q.push_back(rand_req(REQ_PULL));
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_ch.valid || upscaled_q.size() != 0);
    repeat (LAT) @(negedge clk_i);
  endtask

  // never let a replay run into columns not yet written
  task automatic write_reg(input cfg_idx_e idx, input logic [10:0] val);
    logic [10:0] v;
    int unsigned w;
    v = val;
    if (idx == CFG_WIDTH) begin
      w = (v == 0) ? 1 : ((v > MAX_WIDTH) ? MAX_WIDTH : v);
      if (rp_left != 0 && w > written_cnt) v = written_cnt[10:0];
    end
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_SCALE) scale_reg = v[6:0];
    else width_reg = v;
  endtask

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned s;
    int unsigned w;
    int unsigned rows;
    int unsigned ph;
    int unsigned n;
    logic [10:0] sc_val;
    logic [10:0] wd_val;
    bit          partial;
    in_ch.valid    = 1'b0;
    in_ch.req_type = 1'b0;
    in_ch.blue     = 8'h00;
    in_ch.green    = 8'h00;
    in_ch.red      = 8'h00;
    out_ch.ready   = 1'b0;
    for (int i = 0; i < MAX_WIDTH; i++) row_buf[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config: pull with nothing pending, byte extremes
    push_pulls(1);
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'hAA, 8'h55, 8'h0F);
    drain();

    // scale 3, width 2: pixel during replay ignored, surplus pull emits nothing
    write_reg(CFG_SCALE, 11'd3);
    write_reg(CFG_WIDTH, 11'd2);
    @(negedge clk_i);
    push_pixel(8'h01, 8'h80, 8'hFE);
    push_pixel(8'hFE, 8'h7F, 8'h01);
    push_pixel(8'h12, 8'h34, 8'h56);
    push_pulls(5);
    drain();

    // scale change mid-replay, upper data bits ignored
    push_pixel(8'hC3, 8'h3C, 8'h99);
    push_pixel(8'h66, 8'hF0, 8'h0F);
    push_pulls(2);
    drain();
    write_reg(CFG_SCALE, 11'h785);
    @(negedge clk_i);
    push_pulls(2);
    drain();

    // width shrunk mid-row
    write_reg(CFG_SCALE, 11'd2);
    write_reg(CFG_WIDTH, 11'h7FF);
    @(negedge clk_i);
    push_pixel(8'h11, 8'h22, 8'h33);
    push_pixel(8'h44, 8'h55, 8'h66);
    push_pixel(8'h77, 8'h88, 8'h99);
    drain();
    write_reg(CFG_WIDTH, 11'd2);
    @(negedge clk_i);
    push_pixel(8'hDE, 8'hAD, 8'hBE);
    push_pulls(2);
    drain();

    for (ph = 0; produced_cnt < ITEM_GOAL; ph++) begin
      partial = 1'b0;
      case (ph)
        0: begin
          sc_val = 11'd4;
          wd_val = 11'd3;
        end
        1: begin
          sc_val = 11'h07F;
          wd_val = 11'd1;
        end
        2: begin
          sc_val = 11'd0;
          wd_val = 11'd1024;
          partial = 1'b1;
        end
        3: begin
          sc_val = 11'd64;
          wd_val = 11'd0;
        end
        default: begin
          n = $urandom_range(0, 19);
          if (n == 0) begin
            sc_val = 11'($urandom_range(64, 127));
            wd_val = 11'd1;
          end else if (n == 1) begin
            sc_val = 11'($urandom_range(0, 1));
            wd_val = 11'($urandom_range(30, 2047));
            partial = 1'b1;
          end else if (n < 5) begin
            sc_val = 11'($urandom_range(1, 2));
            wd_val = 11'($urandom_range(9, 24));
          end else begin
            sc_val = 11'($urandom_range(0, 6));
            wd_val = 11'($urandom_range(0, 8));
          end
          sc_val[10:7] = 4'($urandom_range(0, 15));
        end
      endcase
      quiet   = (produced_cnt >= QUIET_FROM);
      idle_on = !quiet && (ph == 0 || $urandom_range(0, 9) < 7);
      noisy   = (ph > 3) && ($urandom_range(0, 9) < 6);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_SCALE, sc_val);
        write_reg(CFG_WIDTH, wd_val);
      end else begin
        write_reg(CFG_WIDTH, wd_val);
        write_reg(CFG_SCALE, sc_val);
      end
      @(negedge clk_i);
      s = eff_scale();
      w = eff_width();
      if (ph == 0) sink_hold_req = 1'b1;
      if (partial) begin
        repeat ($urandom_range(3, 10)) req_q.push_back(rand_req(REQ_PIXEL));
      end else begin
        rows = (w * s > 64) ? 1 : $urandom_range(1, 3);
        if (ph == 0) rows = 3;
        for (int unsigned r = 0; r < rows; r++) begin
          fill_row(s, w);
          // between rows the sender at times waits for every outstanding result before going on
          if (r + 1 < rows && (ph == 0 || $urandom_range(0, 5) == 0)) drain();
        end
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
